/* src/assert_macros.svh */
// Assertion macros shared by the posture classifier RTL.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of aclk outside reset.
`define OAPC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("oapc assertion failed");

// Next-cycle implication, checked on the rising edge of aclk outside reset.
`define OAPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("oapc assertion failed");

`endif

/* src/oapc_pkg.sv */
// Package for the orientation average posture classifier.
// Holds the sample type, register map, class codes and pipeline control struct.
// No dependencies.
package oapc_pkg;

    // Angle samples and means: degrees times 128, two's complement.
    localparam int ANGLE_W = 16;
    typedef logic signed [ANGLE_W-1:0] angle_t;

    // Configuration port geometry.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_REST_LOW  = 3'd0,
        REG_REST_HIGH = 3'd1,
        REG_UP_LOW    = 3'd2,
        REG_UP_HIGH   = 3'd3,
        REG_DOWN_LOW  = 3'd4,
        REG_DOWN_HIGH = 3'd5
    } reg_idx_t;

    // Reset values of the band bounds.
    localparam angle_t REST_LOW_RST  = -16'sd2560;
    localparam angle_t REST_HIGH_RST = 16'sd3840;
    localparam angle_t UP_LOW_RST    = 16'sd4480;
    localparam angle_t UP_HIGH_RST   = 16'sd8960;
    localparam angle_t DOWN_LOW_RST  = -16'sd7680;
    localparam angle_t DOWN_HIGH_RST = -16'sd4480;

    typedef struct packed {
        angle_t rest_low;
        angle_t rest_high;
        angle_t up_low;
        angle_t up_high;
        angle_t down_low;
        angle_t down_high;
    } band_cfg_t;

    // Posture class codes.
    localparam int CLASS_W = 2;
    typedef enum logic [CLASS_W-1:0] {
        CLASS_NONE = 2'd0,
        CLASS_REST = 2'd1,
        CLASS_UP   = 2'd2,
        CLASS_DOWN = 2'd3
    } posture_t;

    // Pipeline: window/sum, multiply, estimate, correct, classify.
    localparam int PIPE_DEPTH = 5;

    typedef struct packed {
        logic                  accept;
        logic [PIPE_DEPTH-1:0] load;
        logic [PIPE_DEPTH-1:0] occupied;
    } pipe_ctl_t;

endpackage

/* src/oapc_band_regs.sv */
// APB register block holding the six pitch band bounds.
// Depends on oapc_pkg for the register map and band_cfg_t.
module oapc_band_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [oapc_pkg::ADDR_W-1:0] paddr,
    input  logic [oapc_pkg::DATA_W-1:0] pwdata,
    output logic [oapc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output oapc_pkg::band_cfg_t         band_cfg
);

    oapc_pkg::band_cfg_t  cfg_reg;
    oapc_pkg::reg_idx_t   idx;
    oapc_pkg::angle_t     wr_val;
    oapc_pkg::angle_t     rd_val;
    logic                 wr_en;

    assign pready = 1'b1;
    assign idx    = oapc_pkg::reg_idx_t'(paddr[oapc_pkg::ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign wr_val = oapc_pkg::angle_t'(pwdata[oapc_pkg::ANGLE_W-1:0]);

    // Register writes; indexes past the last register are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rest_low  <= oapc_pkg::REST_LOW_RST;
            cfg_reg.rest_high <= oapc_pkg::REST_HIGH_RST;
            cfg_reg.up_low    <= oapc_pkg::UP_LOW_RST;
            cfg_reg.up_high   <= oapc_pkg::UP_HIGH_RST;
            cfg_reg.down_low  <= oapc_pkg::DOWN_LOW_RST;
            cfg_reg.down_high <= oapc_pkg::DOWN_HIGH_RST;
        end else if (wr_en) begin
            unique case (idx)
                oapc_pkg::REG_REST_LOW:  cfg_reg.rest_low  <= wr_val;
                oapc_pkg::REG_REST_HIGH: cfg_reg.rest_high <= wr_val;
                oapc_pkg::REG_UP_LOW:    cfg_reg.up_low    <= wr_val;
                oapc_pkg::REG_UP_HIGH:   cfg_reg.up_high   <= wr_val;
                oapc_pkg::REG_DOWN_LOW:  cfg_reg.down_low  <= wr_val;
                oapc_pkg::REG_DOWN_HIGH: cfg_reg.down_high <= wr_val;
                default: ;
            endcase
        end
    end

    // Read mux, sign-extended to the bus width.
    always_comb begin
        unique case (idx)
            oapc_pkg::REG_REST_LOW:  rd_val = cfg_reg.rest_low;
            oapc_pkg::REG_REST_HIGH: rd_val = cfg_reg.rest_high;
            oapc_pkg::REG_UP_LOW:    rd_val = cfg_reg.up_low;
            oapc_pkg::REG_UP_HIGH:   rd_val = cfg_reg.up_high;
            oapc_pkg::REG_DOWN_LOW:  rd_val = cfg_reg.down_low;
            oapc_pkg::REG_DOWN_HIGH: rd_val = cfg_reg.down_high;
            default:                 rd_val = '0;
        endcase
    end

    assign prdata   = oapc_pkg::DATA_W'(rd_val);
    assign band_cfg = cfg_reg;

endmodule

/* src/oapc_pipe_ctrl.sv */
// Valid/ready control for the five-stage pipeline.
// Depends on oapc_pkg for pipe_ctl_t and PIPE_DEPTH.
module oapc_pipe_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output oapc_pkg::pipe_ctl_t ctl
);

    localparam int D = oapc_pkg::PIPE_DEPTH;

    logic [D-1:0] vld_reg;
    logic [D-1:0] vld_next;
    logic [D:0]   rdy;

    // A stage may load when it is empty or its content moves on this cycle.
    always_comb begin
        rdy[D] = m_ready;
        for (int k = D - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    // Valid bits follow the data down the pipeline.
    always_comb begin
        vld_next = vld_reg;
        if (rdy[0]) begin
            vld_next[0] = s_valid;
        end
        for (int k = 1; k < D; k++) begin
            if (rdy[k]) begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready      = rdy[0];
    assign m_valid      = vld_reg[D-1];
    assign ctl.accept   = s_valid && rdy[0];
    assign ctl.load     = rdy[D-1:0];
    assign ctl.occupied = vld_reg;

endmodule

/* src/oapc_axis_avg.sv */
// One axis: sample window, running sum and floored division by the window length.
// Depends on oapc_pkg for angle_t and pipe_ctl_t.
module oapc_axis_avg #(
    parameter int WINDOW_LENGTH = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  oapc_pkg::pipe_ctl_t ctl,
    input  oapc_pkg::angle_t    sample,
    output oapc_pkg::angle_t    mean
);

    localparam int CNT_W = $clog2(WINDOW_LENGTH);
    localparam int U_W   = oapc_pkg::ANGLE_W + CNT_W;
    localparam int P_W   = 2 * U_W;
    // Offset that makes every sum non-negative: 32768 times the length.
    localparam logic [U_W-1:0] OFFSET = U_W'(WINDOW_LENGTH) << (oapc_pkg::ANGLE_W - 1);
    // Truncated reciprocal; the estimate is the quotient or one below it.
    localparam logic [U_W-1:0] RECIP  = U_W'((64'd1 << U_W) / WINDOW_LENGTH);
    localparam logic [U_W-1:0] NLEN   = U_W'(WINDOW_LENGTH);

    oapc_pkg::angle_t        win_reg [WINDOW_LENGTH];
    logic signed [U_W-1:0]   sum_reg;
    logic signed [U_W-1:0]   sum_next;
    logic [U_W-1:0]          u1_reg;
    logic [U_W-1:0]          u2_reg;
    logic [P_W-1:0]          prod_reg;
    logic [oapc_pkg::ANGLE_W-1:0] qe_reg;
    logic [U_W-1:0]          qn_reg;
    logic [U_W-1:0]          u3_reg;
    logic [U_W-1:0]          rem;
    logic [oapc_pkg::ANGLE_W-1:0] quot;
    oapc_pkg::angle_t        mean_reg;

    // Running sum: add the new sample, drop the oldest one.
    assign sum_next = sum_reg + U_W'(sample) - U_W'(win_reg[WINDOW_LENGTH-1]);

    // Window shift line and running sum, updated on each accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_LENGTH; i++) begin
                win_reg[i] <= '0;
            end
            sum_reg <= '0;
        end else if (ctl.accept) begin
            win_reg[0] <= sample;
            for (int i = 1; i < WINDOW_LENGTH; i++) begin
                win_reg[i] <= win_reg[i-1];
            end
            sum_reg <= sum_next;
        end
    end

    // Stage 1: offset sum.
    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            u1_reg <= $unsigned(sum_next) + OFFSET;
        end
    end

    // Stage 2: multiply by the reciprocal.
    always_ff @(posedge aclk) begin
        if (ctl.load[1]) begin
            prod_reg <= P_W'(u1_reg) * P_W'(RECIP);
            u2_reg   <= u1_reg;
        end
    end

    // Stage 3: quotient estimate and its product with the length.
    always_ff @(posedge aclk) begin
        if (ctl.load[2]) begin
            qe_reg <= prod_reg[U_W +: oapc_pkg::ANGLE_W];
            qn_reg <= U_W'(prod_reg[P_W-1:U_W] * NLEN);
            u3_reg <= u2_reg;
        end
    end

    // Stage 4: correct the estimate, then remove the offset by flipping the top bit.
    assign rem  = u3_reg - qn_reg;
    assign quot = qe_reg + oapc_pkg::ANGLE_W'(rem >= NLEN);

    always_ff @(posedge aclk) begin
        if (ctl.load[3]) begin
            mean_reg <= oapc_pkg::angle_t'({~quot[oapc_pkg::ANGLE_W-1],
                                             quot[oapc_pkg::ANGLE_W-2:0]});
        end
    end

    assign mean = mean_reg;

endmodule

/* src/orientation_average_posture_classifier_core.sv */
// Top level of the orientation average posture classifier.
// Depends on oapc_pkg, assert_macros.svh, oapc_band_regs, oapc_pipe_ctrl, oapc_axis_avg.
//
//   Channel  | Ports                                      | Moves
//   ---------+--------------------------------------------+-------------------------------
//   input    | s_valid/s_ready, s_*_sample                | one yaw/pitch/roll transaction
//   result   | m_valid/m_ready, m_*_mean, m_posture_class | three means and a posture class
//   config   | psel/penable/pwrite/paddr/pwdata           | one band bound register
//
// One transaction is accepted per cycle unless a result-side stall holds s_ready low.
// The depth is set by the reciprocal multiply, its correction and the band compare.
// Reset clears the windows, running sums and valid bits and loads the band bound reset values.
// A stall on the result side holds only the stages behind a full stage; bubbles close up.
module orientation_average_posture_classifier_core #(
    parameter int WINDOW_LENGTH = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  oapc_pkg::angle_t             s_yaw_sample,
    input  oapc_pkg::angle_t             s_pitch_sample,
    input  oapc_pkg::angle_t             s_roll_sample,
    output logic                         m_valid,
    input  logic                         m_ready,
    output oapc_pkg::angle_t             m_yaw_mean,
    output oapc_pkg::angle_t             m_pitch_mean,
    output oapc_pkg::angle_t             m_roll_mean,
    output logic [oapc_pkg::CLASS_W-1:0] m_posture_class,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [oapc_pkg::ADDR_W-1:0]  paddr,
    input  logic [oapc_pkg::DATA_W-1:0]  pwdata,
    output logic [oapc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    `include "assert_macros.svh"

    localparam int D = oapc_pkg::PIPE_DEPTH;

    oapc_pkg::pipe_ctl_t ctl;
    oapc_pkg::band_cfg_t band_cfg;
    oapc_pkg::angle_t    yaw_mean;
    oapc_pkg::angle_t    pitch_mean;
    oapc_pkg::angle_t    roll_mean;
    oapc_pkg::posture_t  class_next;
    oapc_pkg::angle_t    yaw_reg;
    oapc_pkg::angle_t    pitch_reg;
    oapc_pkg::angle_t    roll_reg;
    oapc_pkg::posture_t  class_reg;

    oapc_band_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .band_cfg (band_cfg)
    );

    oapc_pipe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctl     (ctl)
    );

    oapc_axis_avg #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_yaw (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .sample  (s_yaw_sample),
        .mean    (yaw_mean)
    );

    oapc_axis_avg #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_pitch (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .sample  (s_pitch_sample),
        .mean    (pitch_mean)
    );

    oapc_axis_avg #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_roll (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .sample  (s_roll_sample),
        .mean    (roll_mean)
    );

    // Open band tests on the pitch mean; later bands take priority.
    always_comb begin
        class_next = oapc_pkg::CLASS_NONE;
        if (pitch_mean > band_cfg.rest_low && pitch_mean < band_cfg.rest_high) begin
            class_next = oapc_pkg::CLASS_REST;
        end
        if (pitch_mean > band_cfg.up_low && pitch_mean < band_cfg.up_high) begin
            class_next = oapc_pkg::CLASS_UP;
        end
        if (pitch_mean > band_cfg.down_low && pitch_mean < band_cfg.down_high) begin
            class_next = oapc_pkg::CLASS_DOWN;
        end
    end

    // Stage 5: result register.
    always_ff @(posedge aclk) begin
        if (ctl.load[D-1]) begin
            yaw_reg   <= yaw_mean;
            pitch_reg <= pitch_mean;
            roll_reg  <= roll_mean;
            class_reg <= class_next;
        end
    end

    assign m_yaw_mean      = yaw_reg;
    assign m_pitch_mean    = pitch_reg;
    assign m_roll_mean     = roll_reg;
    assign m_posture_class = class_reg;

    // A full pipeline under a stalled output takes no new transaction.
    `OAPC_ASSERT_IMPL(a_full_blocks_input, (&ctl.occupied) && !m_ready, !s_ready)
    // An accepted transaction occupies the first stage on the next cycle.
    `OAPC_ASSERT_NEXT(a_accept_fills_first, ctl.accept, ctl.occupied[0])
    // A taken result with nothing behind it leaves the output empty.
    `OAPC_ASSERT_NEXT(a_drain_empties_output, m_valid && m_ready && !ctl.occupied[D-2], !m_valid)

endmodule
